>>> rtl/lef_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lef_pkg
// Types, constants and the Laplacian kernel shared by the edge filter.
// ---------------------------------------------------------------------------
package lef_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 13;
  localparam int ROW_W       = 12;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  typedef logic [23:0] rgb_t;

  typedef struct packed {
    logic              drain;
    logic              first;
    logic              top_mid;
    logic              emit_a;
    logic              emit_b;
    logic              eof_b;
    logic [ADDR_W-1:0] addr;
    rgb_t              px;
  } stage_t;

  typedef struct packed {
    rgb_t res_a;
    rgb_t res_b;
    logic has_a;
    logic has_b;
    logic eof_b;
  } entry_t;

  function automatic logic [7:0] lap8(
    input logic [7:0] l0, l1, l2, c0, c1, c2, r0, r1, r2
  );
    logic [10:0]        ring;
    logic [10:0]        centre;
    logic signed [11:0] acc;
    logic [7:0]         res;
    ring = 11'(l0) + 11'(l1) + 11'(l2) + 11'(c0) + 11'(c2)
         + 11'(r0) + 11'(r1) + 11'(r2);
    centre = {c1, 3'b000};
    acc = $signed({1'b0, centre}) - $signed({1'b0, ring});
    if (acc < 12'sd0) begin
      res = 8'd0;
    end else if (acc > 12'sd255) begin
      res = 8'd255;
    end else begin
      res = acc[7:0];
    end
    return res;
  endfunction

  function automatic rgb_t lap_rgb(
    input rgb_t l0, l1, l2, c0, c1, c2, r0, r1, r2
  );
    rgb_t res;
    for (int k = 0; k < 3; k++) begin
      res[8*k +: 8] = lap8(l0[8*k +: 8], l1[8*k +: 8], l2[8*k +: 8],
                           c0[8*k +: 8], c1[8*k +: 8], c2[8*k +: 8],
                           r0[8*k +: 8], r1[8*k +: 8], r2[8*k +: 8]);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> rtl/laplacian_edge_filter_rgb.sv
`default_nettype none
// ---------------------------------------------------------------------------
// laplacian_edge_filter_rgb
// 3x3 Laplacian edge filter over an RGB raster stream with edge replication.
// ---------------------------------------------------------------------------
// The block takes one pixel or flush beat per clock through the whole
// frame unless it stalls as described below. Each beat reads the two line
// memories (registered read) at its column, writes them back in the next
// cycle with forwarding when the following beat hits the same column, shifts
// the 3x3 window, and in the cycle after that the result goes into an
// eight-entry result queue; a beat's results reach the output through stage
// 1, stage 2 and the queue. A row end yields two results, so the queue absorbs
// one extra result per row and the next row's first pixel, which yields none,
// lets it catch up. The input stalls only while the queue plus the two beats in
// flight could overfill it, that is when the output side is stalled.
// The line memories need no clearing pass after reset.
module laplacian_edge_filter_rgb (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [lef_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lef_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          pixel_valid,
  output logic                               pixel_stall,
  input  wire logic [7:0]                    red_in,
  input  wire logic [7:0]                    green_in,
  input  wire logic [7:0]                    blue_in,
  input  wire logic                          flush,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [7:0]                         red_out,
  output logic [7:0]                         green_out,
  output logic [7:0]                         blue_out,
  output logic                               end_of_row,
  output logic                               end_of_frame
);

  logic [lef_pkg::WIDTH_W-1:0]  image_width;
  logic [lef_pkg::HEIGHT_W-1:0] image_height;
  logic [lef_pkg::WIDTH_W-1:0]  w_eff;
  logic [lef_pkg::HEIGHT_W-1:0] h_eff;

  logic [lef_pkg::ADDR_W-1:0] column_count;
  logic [lef_pkg::ROW_W-1:0]  row_count;
  logic [lef_pkg::ADDR_W-1:0] drain_count;
  logic                       draining;

  logic [lef_pkg::ADDR_W-1:0] pix_x;
  logic [lef_pkg::ROW_W-1:0]  pix_y;
  logic                       pix_last;
  logic                       row_last;
  logic                       drain_last;
  logic                       accept;
  logic                       work;
  lef_pkg::stage_t            s0;

  lef_pkg::rgb_t upper_mem  [lef_pkg::MAX_WIDTH];
  lef_pkg::rgb_t middle_mem [lef_pkg::MAX_WIDTH];
  lef_pkg::rgb_t rd_u;
  lef_pkg::rgb_t rd_m;
  lef_pkg::rgb_t fwd_u;
  lef_pkg::rgb_t fwd_m;
  logic          fwd_hit;

  lef_pkg::stage_t s1;
  logic            s1_valid;
  lef_pkg::rgb_t   up_eff;
  lef_pkg::rgb_t   mid_eff;
  lef_pkg::rgb_t   top;
  lef_pkg::rgb_t   bot;
  lef_pkg::rgb_t   win [9];

  lef_pkg::stage_t s2;
  logic            s2_valid;
  lef_pkg::entry_t push_entry;

  lef_pkg::entry_t                q_mem [lef_pkg::QUEUE_DEPTH];
  logic [lef_pkg::QUEUE_AW-1:0]   wr_ptr;
  logic [lef_pkg::QUEUE_AW-1:0]   rd_ptr;
  logic [lef_pkg::QUEUE_AW:0]     q_count;
  logic [lef_pkg::QUEUE_AW:0]     q_count_next;
  lef_pkg::entry_t                head;
  logic                           half;
  logic                           show_b;
  logic                           take;
  logic                           pop;
  lef_pkg::rgb_t                  out_px;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= lef_pkg::WIDTH_W'(640);
      image_height <= lef_pkg::HEIGHT_W'(480);
    end else if (cfg_write) begin
      case (cfg_index)
        lef_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[lef_pkg::WIDTH_W-1:0];
        lef_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[lef_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = lef_pkg::WIDTH_W'(1);
    end else if (image_width > lef_pkg::WIDTH_W'(lef_pkg::MAX_WIDTH)) begin
      w_eff = lef_pkg::WIDTH_W'(lef_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = lef_pkg::HEIGHT_W'(1);
    end else if (image_height > lef_pkg::HEIGHT_W'(lef_pkg::MAX_HEIGHT)) begin
      h_eff = lef_pkg::HEIGHT_W'(lef_pkg::MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  // stage 0: position, read address, result plan
  assign accept = pixel_valid && !pixel_stall;
  assign work   = accept && (!flush || draining);
  assign pix_x  = draining ? '0 : column_count;
  assign pix_y  = draining ? '0 : row_count;
  assign pix_last   = (lef_pkg::WIDTH_W'(pix_x) + lef_pkg::WIDTH_W'(1)) >= w_eff;
  assign drain_last = (lef_pkg::WIDTH_W'(drain_count) + lef_pkg::WIDTH_W'(1)) >= w_eff;
  assign row_last   = (lef_pkg::HEIGHT_W'(pix_y) + lef_pkg::HEIGHT_W'(1)) >= h_eff;

  always_comb begin
    s0.drain   = flush;
    s0.addr    = flush ? drain_count : pix_x;
    s0.first   = flush ? (drain_count == '0) : (pix_x == '0);
    s0.top_mid = flush ? (row_count == '0) : (pix_y == lef_pkg::ROW_W'(1));
    s0.emit_a  = flush ? (drain_count != '0) : ((pix_y != '0) && (pix_x != '0));
    s0.emit_b  = flush ? drain_last : ((pix_y != '0) && pix_last);
    s0.eof_b   = flush;
    s0.px      = {blue_in, green_in, red_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      drain_count  <= '0;
      draining     <= 1'b0;
    end else if (accept) begin
      if (flush) begin
        if (draining) begin
          if (drain_last) begin
            draining     <= 1'b0;
            drain_count  <= '0;
            row_count    <= '0;
            column_count <= '0;
          end else begin
            drain_count <= drain_count + lef_pkg::ADDR_W'(1);
          end
        end
      end else begin
        draining     <= pix_last && row_last;
        drain_count  <= '0;
        column_count <= pix_last ? '0 : pix_x + lef_pkg::ADDR_W'(1);
        row_count    <= (pix_last && !row_last) ? pix_y + lef_pkg::ROW_W'(1) : pix_y;
      end
    end
  end

  // line memories: read in stage 0, write back in stage 1
  always_ff @(posedge clk) begin
    rd_u <= upper_mem[s0.addr];
    rd_m <= middle_mem[s0.addr];
    if (s1_valid && !s1.drain) begin
      upper_mem[s1.addr]  <= mid_eff;
      middle_mem[s1.addr] <= s1.px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit  <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      fwd_hit  <= s1_valid && !s1.drain && work && (s0.addr == s1.addr);
      s1_valid <= work;
      s2_valid <= s1_valid && (s1.emit_a || s1.emit_b);
    end
  end

  always_ff @(posedge clk) begin
    fwd_u <= mid_eff;
    fwd_m <= s1.px;
    s1    <= s0;
    s2    <= s1;
  end

  // stage 1: resolve column, shift window
  assign up_eff  = fwd_hit ? fwd_u : rd_u;
  assign mid_eff = fwd_hit ? fwd_m : rd_m;
  assign top     = s1.top_mid ? mid_eff : up_eff;
  assign bot     = s1.drain ? mid_eff : s1.px;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      if (s1.first) begin
        for (int c = 0; c < 3; c++) begin
          win[c*3+0] <= top;
          win[c*3+1] <= mid_eff;
          win[c*3+2] <= bot;
        end
      end else begin
        for (int c = 0; c < 6; c++) begin
          win[c] <= win[c+3];
        end
        win[6] <= top;
        win[7] <= mid_eff;
        win[8] <= bot;
      end
    end
  end

  // stage 2: kernel, push into result queue
  always_comb begin
    push_entry.res_a = lef_pkg::lap_rgb(win[0], win[1], win[2], win[3], win[4],
                                        win[5], win[6], win[7], win[8]);
    push_entry.res_b = lef_pkg::lap_rgb(win[3], win[4], win[5], win[6], win[7],
                                        win[8], win[6], win[7], win[8]);
    push_entry.has_a = s2.emit_a;
    push_entry.has_b = s2.emit_b;
    push_entry.eof_b = s2.eof_b;
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      q_mem[wr_ptr] <= push_entry;
    end
  end

  assign head   = q_mem[rd_ptr];
  assign show_b = half || !head.has_a;
  assign take   = result_valid && !result_stall;
  assign pop    = take && (show_b || !head.has_b);

  always_comb begin
    q_count_next = q_count;
    if (s2_valid && !pop) begin
      q_count_next = q_count + (lef_pkg::QUEUE_AW+1)'(1);
    end else if (!s2_valid && pop) begin
      q_count_next = q_count - (lef_pkg::QUEUE_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
      half    <= 1'b0;
    end else begin
      if (s2_valid) begin
        wr_ptr <= wr_ptr + lef_pkg::QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + lef_pkg::QUEUE_AW'(1);
      end
      if (take) begin
        half <= !pop;
      end
      q_count <= q_count_next;
    end
  end

  assign pixel_stall = ((lef_pkg::QUEUE_AW+2)'(q_count) + (lef_pkg::QUEUE_AW+2)'(s1_valid)
                       + (lef_pkg::QUEUE_AW+2)'(s2_valid))
                       >= (lef_pkg::QUEUE_AW+2)'(lef_pkg::QUEUE_DEPTH);

  assign result_valid = (q_count != '0);
  assign out_px       = show_b ? head.res_b : head.res_a;
  assign red_out      = out_px[7:0];
  assign green_out    = out_px[15:8];
  assign blue_out     = out_px[23:16];
  assign end_of_row   = show_b;
  assign end_of_frame = show_b && head.eof_b;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= (lef_pkg::QUEUE_AW+1)'(lef_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_fwd_source: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> $past(s1_valid && !s1.drain))
    else $error("forward taken without a preceding line write");

  a_idle_flush: assert property (@(posedge clk) disable iff (rst)
    (accept && flush && !draining) |=> !s1_valid)
    else $error("flush outside drain entered the pipeline");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && end_of_frame) |-> end_of_row)
    else $error("frame end without row end");

endmodule
`default_nettype wire

>>> dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB Laplacian edge filter.
// Raster frames and drain flushes are fed through a valid/stall driver with
// random gaps. A bit-level copy of the filter in the bench predicts every
// output beat: it keeps its own line memories, window and counters. The
// output side stalls at random and holds off once for a long stretch. A
// short directed opening covers extreme pixel values, stray flushes, an
// abandoned drain, out-of-range register values and mid-frame shrinking.
// Random frames of varied size and shape follow.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       flush;
  } raster_beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       eor;
    logic       eof;
  } filtered_px_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [lef_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lef_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          pixel_valid = 1'b0;
  logic                          pixel_stall;
  logic [7:0]                    red_in = '0;
  logic [7:0]                    green_in = '0;
  logic [7:0]                    blue_in = '0;
  logic                          flush = 1'b0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  logic [7:0]                    red_out;
  logic [7:0]                    green_out;
  logic [7:0]                    blue_out;
  logic                          end_of_row;
  logic                          end_of_frame;

  laplacian_edge_filter_rgb i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .flush        (flush),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .end_of_row   (end_of_row),
    .end_of_frame (end_of_frame)
  );

  always #5ns clk = ~clk;

  // Filter state as the bench sees it
  logic [lef_pkg::WIDTH_W-1:0]  img_width = 11'd640;
  logic [lef_pkg::HEIGHT_W-1:0] img_height = 13'd480;
  lef_pkg::rgb_t                upper_mem [lef_pkg::MAX_WIDTH];
  lef_pkg::rgb_t                middle_mem [lef_pkg::MAX_WIDTH];
  lef_pkg::rgb_t                kernel_win [9];
  int                           col_q = 0;
  int                           row_q = 0;
  int                           drain_q = 0;
  bit                           drain_on = 1'b0;

  raster_beat_t raster_feed [$];
  filtered_px_t expected_pixels [$];
  raster_beat_t beat_now;
  int           mismatches = 0;
  int           results_seen = 0;
  int           fed_beats = 0;
  int           gap_left = 0;
  int           in_calm = 0;
  int           stall_left = 0;
  int           out_calm = 0;
  int           hold_left = 0;
  bit           hold_asked = 1'b0;
  bit           hold_done = 1'b0;
  int           quiet_cycles = 0;

  initial begin
    for (int i = 0; i < lef_pkg::MAX_WIDTH; i++) begin
      upper_mem[i] = '0;
      middle_mem[i] = '0;
    end
    for (int i = 0; i < 9; i++) kernel_win[i] = '0;
  end

  function automatic int eff_width();
    int w;
    w = int'(img_width);
    if (w < 1) w = 1;
    if (w > lef_pkg::MAX_WIDTH) w = lef_pkg::MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = int'(img_height);
    if (h < 1) h = 1;
    if (h > lef_pkg::MAX_HEIGHT) h = lef_pkg::MAX_HEIGHT;
    return h;
  endfunction

  function automatic int pick_gap(inout int calm);
    int roll;
    int g;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 199);
    if (roll < 2) begin
      calm = $urandom_range(40, 150);
      g = 0;
    end else if (roll < 110) begin
      g = 0;
    end else if (roll < 170) begin
      g = $urandom_range(1, 3);
    end else if (roll < 194) begin
      g = $urandom_range(4, 12);
    end else begin
      g = $urandom_range(20, 60);
    end
    return g;
  endfunction

  // Column 0 of the window is the left one; rows run top to bottom
  function automatic void shift_window(lef_pkg::rgb_t top, lef_pkg::rgb_t mid,
                                       lef_pkg::rgb_t bot, bit first);
    if (first) begin
      for (int c = 0; c < 3; c++) begin
        kernel_win[c*3]     = top;
        kernel_win[c*3 + 1] = mid;
        kernel_win[c*3 + 2] = bot;
      end
    end else begin
      for (int c = 0; c < 6; c++) kernel_win[c] = kernel_win[c + 3];
      kernel_win[6] = top;
      kernel_win[7] = mid;
      kernel_win[8] = bot;
    end
  endfunction

  function automatic logic [7:0] channel_laplacian(int lc, int cc, int rc, int sh);
    int cols [3];
    int acc;
    int v;
    cols = '{lc, cc, rc};
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      for (int r = 0; r < 3; r++) begin
        v = int'((kernel_win[cols[i]*3 + r] >> sh) & 24'hFF);
        if (i == 1 && r == 1) acc += 8 * v;
        else acc -= v;
      end
    end
    if (acc > 255) acc = 255;
    if (acc < 0) acc = 0;
    return 8'(acc);
  endfunction

  function automatic void enqueue_filtered(int lc, int cc, int rc, bit eor, bit eof);
    filtered_px_t px;
    px.red   = channel_laplacian(lc, cc, rc, 0);
    px.green = channel_laplacian(lc, cc, rc, 8);
    px.blue  = channel_laplacian(lc, cc, rc, 16);
    px.eor   = eor;
    px.eof   = eof;
    expected_pixels.push_back(px);
  endfunction

  function automatic void advance_raster(raster_beat_t b);
    int            w;
    int            h;
    int            d;
    int            x;
    int            y;
    lef_pkg::rgb_t m;
    lef_pkg::rgb_t u;
    lef_pkg::rgb_t top;
    lef_pkg::rgb_t px;
    w = eff_width();
    h = eff_height();
    if (b.flush) begin
      if (!drain_on) return;
      d = drain_q;
      if (d >= lef_pkg::MAX_WIDTH) d = lef_pkg::MAX_WIDTH - 1;
      m = middle_mem[d];
      u = upper_mem[d];
      top = (row_q == 0) ? m : u;
      shift_window(top, m, m, d == 0);
      if (d >= 1) enqueue_filtered(0, 1, 2, 1'b0, 1'b0);
      if (d + 1 >= w) begin
        enqueue_filtered(1, 2, 2, 1'b1, 1'b1);
        drain_on = 1'b0;
        drain_q = 0;
        row_q = 0;
        col_q = 0;
      end else begin
        drain_q = d + 1;
      end
    end else begin
      if (drain_on) begin
        drain_on = 1'b0;
        drain_q = 0;
        row_q = 0;
        col_q = 0;
      end
      x = col_q;
      if (x >= lef_pkg::MAX_WIDTH) x = lef_pkg::MAX_WIDTH - 1;
      y = row_q;
      px = {b.blue, b.green, b.red};
      u = upper_mem[x];
      m = middle_mem[x];
      upper_mem[x] = m;
      middle_mem[x] = px;
      top = (y == 1) ? m : u;
      shift_window(top, m, px, x == 0);
      if (y >= 1) begin
        if (x >= 1) enqueue_filtered(0, 1, 2, 1'b0, 1'b0);
        if (x + 1 >= w) enqueue_filtered(1, 2, 2, 1'b1, 1'b0);
      end
      if (x + 1 >= w) begin
        col_q = 0;
        if (y + 1 >= h) drain_on = 1'b1;
        else row_q = y + 1;
      end else begin
        col_q = x + 1;
      end
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Input driver
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall) advance_raster(beat_now);
      if (!pixel_valid || !pixel_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          pixel_valid <= 1'b0;
        end else if (raster_feed.size() > 0) begin
          beat_now = raster_feed.pop_front();
          red_in      <= beat_now.red;
          green_in    <= beat_now.green;
          blue_in     <= beat_now.blue;
          flush       <= beat_now.flush;
          pixel_valid <= 1'b1;
          gap_left = pick_gap(in_calm);
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // Output stall generator
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (hold_asked && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      stall_left = pick_gap(out_calm);
    end
  end

  // Output monitor
  always @(posedge clk) begin
    filtered_px_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("output beat with nothing expected");
      end else begin
        want = expected_pixels.pop_front();
        check_field("red_out", red_out, want.red);
        check_field("green_out", green_out, want.green);
        check_field("blue_out", blue_out, want.blue);
        check_field("end_of_row", {7'd0, end_of_row}, {7'd0, want.eor});
        check_field("end_of_frame", {7'd0, end_of_frame}, {7'd0, want.eof});
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall) || cfg_write)
    begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [lef_pkg::CFG_IDX_W-1:0] idx,
                           logic [lef_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == lef_pkg::REG_IMAGE_WIDTH) img_width = data[lef_pkg::WIDTH_W-1:0];
    else img_height = data[lef_pkg::HEIGHT_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (raster_feed.size() != 0 || pixel_valid || expected_pixels.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    raster_beat_t beat;
    beat.red   = r;
    beat.green = g;
    beat.blue  = b;
    beat.flush = 1'b0;
    raster_feed.push_back(beat);
    fed_beats++;
  endtask

  task automatic push_flushes(int n);
    raster_beat_t beat;
    beat.red   = 8'($urandom);
    beat.green = 8'($urandom);
    beat.blue  = 8'($urandom);
    beat.flush = 1'b1;
    repeat (n) raster_feed.push_back(beat);
    fed_beats += n;
  endtask

  function automatic logic [7:0] pick_level(bit smooth, logic [7:0] base);
    int roll;
    if (smooth) return base + 8'($urandom_range(0, 7));
    roll = $urandom_range(0, 99);
    if (roll < 20) return 8'd0;
    if (roll < 40) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  // Smooth stretches keep results off the upper clamp
  task automatic push_rows(int n);
    bit         smooth;
    logic [7:0] base_r;
    logic [7:0] base_g;
    logic [7:0] base_b;
    smooth = ($urandom_range(0, 3) == 0);
    base_r = 8'($urandom_range(8, 240));
    base_g = 8'($urandom_range(8, 240));
    base_b = 8'($urandom_range(8, 240));
    repeat (n) push_pixel(pick_level(smooth, base_r), pick_level(smooth, base_g),
                          pick_level(smooth, base_b));
  endtask

  initial begin
    int                        cap;
    int                        w_pick;
    int                        h_pick;
    int                        roll;
    int                        wn;
    int                        npx;
    bit                        at_start;
    logic [lef_pkg::CFG_W-1:0] wdata;
    logic [lef_pkg::CFG_W-1:0] hdata;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // 3x2 frame of extreme pixels, preceded by a flush outside any drain
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 13'd3);
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 13'd2);
    push_flushes(1);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd255, 8'd0, 8'd255);
    push_pixel(8'd0, 8'd255, 8'd0);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd0, 8'd0, 8'd0);
    push_flushes(3);
    wait_idle();

    // zero width and height act as one; pixel during drain restarts the frame
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 13'h1800);
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 13'd0);
    push_pixel(8'd255, 8'd0, 8'd128);
    push_pixel(8'd0, 8'd255, 8'd1);
    push_flushes(2);
    wait_idle();

    // shrink width and height in the middle of a frame
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 13'd4);
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 13'd3);
    push_rows(6);
    wait_idle();
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 13'd2);
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 13'd2);
    push_rows(1);
    push_flushes(2);
    wait_idle();

    // long output hold-off while the input keeps offering
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 13'd16);
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 13'd6);
    push_rows(96);
    push_flushes(16);
    hold_asked = 1'b1;
    wait_idle();

    // width above the maximum, then shrink it in the middle of the row
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 13'h07FF);
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 13'd1);
    push_rows(100);
    wait_idle();
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 13'd60);
    push_rows(1);
    push_flushes(60);
    wait_idle();

    // all height bits set, then cut the frame short below the current row
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 13'd2);
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 13'h1FFF);
    push_rows(6);
    wait_idle();
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 13'd2);
    push_rows(2);
    push_flushes(2);
    wait_idle();

    while (fed_beats < 750) begin
      // widen only at a frame start so no unwritten line entry is used
      at_start = (row_q == 0 && col_q == 0 && !drain_on);
      cap = at_start ? 48 : eff_width();
      if ($urandom_range(0, 99) < 80) w_pick = $urandom_range(1, (cap < 12) ? cap : 12);
      else w_pick = $urandom_range(1, cap);
      if ($urandom_range(0, 99) < 85) h_pick = $urandom_range(1, 5);
      else h_pick = $urandom_range(6, 12);
      wdata = lef_pkg::CFG_W'(w_pick);
      if ($urandom_range(0, 15) == 0) wdata = '0;
      if ($urandom_range(0, 3) == 0) begin
        wdata[lef_pkg::CFG_W-1:lef_pkg::WIDTH_W] = 2'($urandom_range(1, 3));
      end
      hdata = lef_pkg::CFG_W'(h_pick);
      if ($urandom_range(0, 15) == 0) hdata = '0;
      roll = $urandom_range(0, 9);
      if (roll != 0) write_reg(lef_pkg::REG_IMAGE_WIDTH, wdata);
      if (roll != 1) write_reg(lef_pkg::REG_IMAGE_HEIGHT, hdata);

      wn = eff_width();
      npx = wn * eff_height();
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        push_rows(npx);
        push_flushes(wn);
      end else if (roll < 72) begin
        push_flushes($urandom_range(1, 3));
        push_rows(npx);
        push_flushes(wn);
      end else if (roll < 85) begin
        // drain cut short by the next frame
        push_rows(npx);
        push_flushes($urandom_range(0, wn - 1));
        push_rows(npx);
        push_flushes(wn);
      end else begin
        npx = $urandom_range(1, npx);
        push_rows(npx);
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
